>>> src/fpm_pkg.sv
// Package for the frame pacing monitor: payload structs, command codes,
// register map and reset values. No dependencies.
`timescale 1ns / 1ps

package fpm_pkg;

    // Storage widths handed down as top-level parameter defaults
    localparam int FPM_STAMP_BITS = 48;
    localparam int FPM_COUNT_BITS = 32;

    // Configuration port
    localparam int FPM_ADDR_W = 3;
    localparam int FPM_DATA_W = 32;
    localparam logic FPM_REG_FROZEN = 1'b0;
    localparam logic FPM_REG_SLOW   = 1'b1;

    localparam logic [23:0] FPM_FROZEN_RESET = 24'd700000;
    localparam logic [7:0]  FPM_SLOW_RESET   = 8'd24;   // 1.5 in Q4

    typedef enum logic [1:0] {
        CMD_FRAME   = 2'd0,
        CMD_TAKE    = 2'd1,
        CMD_RESTART = 2'd2
    } fpm_cmd_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [47:0] timestamp_us;
        logic [23:0] expected_interval_us;
    } fpm_in_t;

    typedef struct packed {
        logic [31:0] frame_count;
        logic [47:0] interval_us;
        logic [47:0] max_gap_us;
        logic [31:0] slow_count;
        logic [31:0] frozen_count;
    } fpm_out_t;

    typedef struct packed {
        logic [23:0] frozen_threshold_us;
        logic [7:0]  slow_factor_q4;
    } fpm_cfg_t;

endpackage

>>> src/fpm_regs.sv
// Configuration registers of the frame pacing monitor behind an APB-style port.
// Depends on fpm_pkg.
`timescale 1ns / 1ps

module fpm_regs import fpm_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [FPM_ADDR_W-1:0] paddr,
    input  logic [FPM_DATA_W-1:0] pwdata,
    output logic [FPM_DATA_W-1:0] prdata,
    output logic                  pready,
    output fpm_cfg_t              cfg
);

    logic [23:0] frozen_reg;
    logic [23:0] frozen_next;
    logic [7:0]  slow_reg;
    logic [7:0]  slow_next;
    logic        wr_en;
    logic        reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb begin
        frozen_next = frozen_reg;
        slow_next   = slow_reg;
        if (wr_en) begin
            case (reg_sel)
                FPM_REG_FROZEN: frozen_next = pwdata[23:0];
                FPM_REG_SLOW:   slow_next   = pwdata[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frozen_reg <= FPM_FROZEN_RESET;
            slow_reg   <= FPM_SLOW_RESET;
        end else begin
            frozen_reg <= frozen_next;
            slow_reg   <= slow_next;
        end
    end

    always_comb begin
        case (reg_sel)
            FPM_REG_FROZEN: prdata = {8'd0, frozen_reg};
            FPM_REG_SLOW:   prdata = {24'd0, slow_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.frozen_threshold_us = frozen_reg;
    assign cfg.slow_factor_q4      = slow_reg;

endmodule

>>> src/fpm_core.sv
// Window state and per-request classification of the frame pacing monitor.
// Depends on fpm_pkg.
`timescale 1ns / 1ps

module fpm_core import fpm_pkg::*; #(
    parameter int STAMP_BITS = FPM_STAMP_BITS,
    parameter int COUNT_BITS = FPM_COUNT_BITS
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     step_en,
    input  fpm_in_t  item,
    input  fpm_cfg_t cfg,
    output fpm_out_t window
);

    localparam int PROD_W = STAMP_BITS + 8;

    logic [STAMP_BITS-1:0] last_stamp_reg,   last_stamp_next;
    logic [STAMP_BITS-1:0] shortest_gap_reg, shortest_gap_next;
    logic [STAMP_BITS-1:0] win_interval_reg, win_interval_next;
    logic [STAMP_BITS-1:0] win_max_gap_reg,  win_max_gap_next;
    logic [COUNT_BITS-1:0] win_frames_reg,   win_frames_next;
    logic [COUNT_BITS-1:0] win_slow_reg,     win_slow_next;
    logic [COUNT_BITS-1:0] win_frozen_reg,   win_frozen_next;

    logic [STAMP_BITS-1:0] stamp;
    logic [STAMP_BITS-1:0] expected;
    logic [STAMP_BITS-1:0] gap;
    logic [STAMP_BITS-1:0] short_pick;
    logic [STAMP_BITS-1:0] interval;
    logic [PROD_W-1:0]     gap_q4;
    logic [PROD_W-1:0]     limit;
    logic                  measured;
    logic                  frozen_hit;
    logic                  slow_hit;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        sat_inc = (c == '1) ? c : c + 1'b1;
    endfunction

    assign stamp    = STAMP_BITS'(item.timestamp_us);
    assign expected = STAMP_BITS'(item.expected_interval_us);
    assign gap      = stamp - last_stamp_reg;
    assign measured = (last_stamp_reg != '0) && (stamp > last_stamp_reg);

    // Track the shortest gap only while no platform interval is known
    assign short_pick = (shortest_gap_reg == '0 || gap < shortest_gap_reg) ?
                        gap : shortest_gap_reg;
    assign interval   = (expected != '0) ? expected : short_pick;

    // Slow when gap * 16 exceeds interval * factor, compared exactly
    assign gap_q4     = {4'd0, gap, 4'd0};
    assign limit      = PROD_W'(interval) * PROD_W'(cfg.slow_factor_q4);
    assign frozen_hit = gap >= STAMP_BITS'(cfg.frozen_threshold_us);
    assign slow_hit   = !frozen_hit && (interval != '0) && (gap_q4 > limit);

    always_comb begin
        last_stamp_next   = last_stamp_reg;
        shortest_gap_next = shortest_gap_reg;
        win_interval_next = win_interval_reg;
        win_max_gap_next  = win_max_gap_reg;
        win_frames_next   = win_frames_reg;
        win_slow_next     = win_slow_reg;
        win_frozen_next   = win_frozen_reg;
        if (step_en) begin
            case (item.cmd)
                CMD_FRAME: begin
                    last_stamp_next = stamp;
                    if (measured) begin
                        if (expected == '0) begin
                            shortest_gap_next = short_pick;
                        end
                        win_frames_next   = sat_inc(win_frames_reg);
                        win_interval_next = interval;
                        if (gap > win_max_gap_reg) begin
                            win_max_gap_next = gap;
                        end
                        if (frozen_hit) begin
                            win_frozen_next = sat_inc(win_frozen_reg);
                        end else if (slow_hit) begin
                            win_slow_next = sat_inc(win_slow_reg);
                        end
                    end
                end
                CMD_TAKE: begin
                    win_interval_next = '0;
                    win_max_gap_next  = '0;
                    win_frames_next   = '0;
                    win_slow_next     = '0;
                    win_frozen_next   = '0;
                end
                CMD_RESTART: begin
                    last_stamp_next   = '0;
                    win_interval_next = '0;
                    win_max_gap_next  = '0;
                    win_frames_next   = '0;
                    win_slow_next     = '0;
                    win_frozen_next   = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_stamp_reg   <= '0;
            shortest_gap_reg <= '0;
            win_interval_reg <= '0;
            win_max_gap_reg  <= '0;
            win_frames_reg   <= '0;
            win_slow_reg     <= '0;
            win_frozen_reg   <= '0;
        end else begin
            last_stamp_reg   <= last_stamp_next;
            shortest_gap_reg <= shortest_gap_next;
            win_interval_reg <= win_interval_next;
            win_max_gap_reg  <= win_max_gap_next;
            win_frames_reg   <= win_frames_next;
            win_slow_reg     <= win_slow_next;
            win_frozen_reg   <= win_frozen_next;
        end
    end

    assign window.frame_count  = 32'(win_frames_reg);
    assign window.interval_us  = 48'(win_interval_reg);
    assign window.max_gap_us   = 48'(win_max_gap_reg);
    assign window.slow_count   = 32'(win_slow_reg);
    assign window.frozen_count = 32'(win_frozen_reg);

`ifndef SYNTHESIS
    a_interval_with_frames: assert property (@(posedge aclk) disable iff (!aresetn)
        win_frames_reg != '0 |-> win_interval_reg != '0)
        else $error("window holds frames but no interval");

    a_restart_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.cmd == CMD_RESTART |=>
            last_stamp_reg == '0 && win_frames_reg == '0 && win_max_gap_reg == '0)
        else $error("restart left state behind");

    a_max_gap_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && item.cmd == CMD_FRAME |=> win_max_gap_reg >= $past(win_max_gap_reg))
        else $error("largest gap shrank on a frame");
`endif

endmodule

>>> src/frame_pacing_monitor.sv
// Top level of the frame pacing monitor: input register, result register and
// the configuration port. Depends on fpm_pkg, fpm_regs and fpm_core.
`timescale 1ns / 1ps

// Frame pacing monitor. Each request on the s_ channel carries a command: a
// frame timestamp in microseconds, a take of the current window, or a restart.
// A frame is measured when a nonzero earlier timestamp is held and the new one
// is later; its gap bumps the frame count, raises the largest gap, picks the
// interval in use (the expected interval if nonzero, else the shortest gap
// seen on frames without one since reset) and is classed frozen (gap at or
// above the frozen threshold) or else slow (gap * 16 above interval * slow
// factor). Counters saturate. A take returns one result on the m_ channel with
// the window as it stood and clears it; restart clears the last timestamp and
// the window but keeps the shortest gap. Every request is held in the input
// register and is then folded into the window state by combinational logic,
// so the block takes one request per clock; the only stall comes from a take
// meeting a result register that is still full and not being read.
// Configuration registers (frozen threshold at 0x0, slow factor in unsigned
// Q4 at 0x4) are to be written only while idle.
module frame_pacing_monitor import fpm_pkg::*; #(
    parameter int STAMP_BITS = FPM_STAMP_BITS,
    parameter int COUNT_BITS = FPM_COUNT_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // Request channel
    input  logic                  s_valid,
    output logic                  s_ready,
    input  fpm_in_t               s_data,
    // Result channel
    output logic                  m_valid,
    input  logic                  m_ready,
    output fpm_out_t              m_data,
    // Configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [FPM_ADDR_W-1:0] paddr,
    input  logic [FPM_DATA_W-1:0] pwdata,
    output logic [FPM_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic     in_vld_reg, in_vld_next;
    fpm_in_t  in_data_reg;
    logic     out_vld_reg, out_vld_next;
    fpm_out_t out_data_reg;

    fpm_cfg_t cfg;
    fpm_out_t window;
    logic     in_fire;
    logic     proc_fire;
    logic     take_fire;

    fpm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fpm_core #(
        .STAMP_BITS (STAMP_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (proc_fire),
        .item    (in_data_reg),
        .cfg     (cfg),
        .window  (window)
    );

    // Advance the held request unless it is a take and the result slot is
    // still occupied and not being drained this cycle.
    assign proc_fire = in_vld_reg &&
                       (in_data_reg.cmd != CMD_TAKE || !out_vld_reg || m_ready);
    assign take_fire = proc_fire && (in_data_reg.cmd == CMD_TAKE);
    assign s_ready   = !in_vld_reg || proc_fire;
    assign in_fire   = s_valid && s_ready;

    always_comb begin
        in_vld_next = in_vld_reg;
        if (in_fire) begin
            in_vld_next = 1'b1;
        end else if (proc_fire) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (take_fire) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Hold payloads; no reset needed
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_data_reg <= s_data;
        end
        if (take_fire) begin
            out_data_reg <= window;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

`ifndef SYNTHESIS
    a_result_from_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_vld_reg) |-> $past(take_fire))
        else $error("result appeared without a take");

    a_stall_only_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !s_ready |-> in_data_reg.cmd == CMD_TAKE && out_vld_reg)
        else $error("input stalled without a pending take");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && in_vld_reg |-> proc_fire)
        else $error("held request overwritten before use");
`endif

endmodule

>>> tb/sv/frame_pacing_monitor_test.sv
// Self-checking testbench for frame_pacing_monitor: a queued driver, a result monitor,
// a transaction-level predictor of the pacing window and an APB register sequencer.
// Depends on fpm_pkg and the frame_pacing_monitor RTL.
`timescale 1ns / 1ps

module frame_pacing_monitor_test;
    import fpm_pkg::*;

    // Command 3 is not decoded by the block; it must leave every bit of state alone
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int SETTLE_CYCLES   = 8;     // margin for the last result to leave the block
    localparam int HOLD_OFF_CYCLES = 300;   // long receiver stall in the pressure phase
    localparam int WATCHDOG_LIMIT  = 4000;  // cycles with no request or result moving
    localparam int PHASE_COUNT     = 6;
    localparam int PHASE_ITEMS     = 300;
    localparam int PRESSURE_PHASE  = 1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    fpm_in_t               s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    fpm_out_t              m_data;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [FPM_ADDR_W-1:0] paddr = '0;
    logic [FPM_DATA_W-1:0] pwdata = '0;
    logic [FPM_DATA_W-1:0] prdata;
    logic                  pready;

    frame_pacing_monitor i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Requests waiting for the driver, and window reports the predictor has promised
    fpm_in_t  pending_requests[$];
    fpm_out_t window_reports_due[$];
    int       mismatches = 0;
    int       idle_cycles = 0;
    logic     hold_off_due = 1'b0;

    // Driver burst and gap counters
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    // Receiver stall pattern and hold-off state
    logic [15:0] ready_pattern = '1;
    int unsigned pattern_age = 0;
    int unsigned hold_left = 0;
    logic        hold_off_taken = 1'b0;

    // Shadow of the block's state and registers, kept at the block's own widths
    logic [47:0] prior_stamp = '0;
    logic [47:0] shortest_gap_seen = '0;
    logic [31:0] window_frames = '0;
    logic [47:0] window_interval = '0;
    logic [47:0] window_max_gap = '0;
    logic [31:0] window_slow = '0;
    logic [31:0] window_frozen = '0;
    logic [23:0] cfg_frozen_threshold = FPM_FROZEN_RESET;
    logic [7:0]  cfg_slow_factor = FPM_SLOW_RESET;

    function automatic logic [31:0] bump(input logic [31:0] count);
        return (&count) ? count : count + 32'd1;
    endfunction

    function automatic void clear_window();
        window_frames = '0;
        window_interval = '0;
        window_max_gap = '0;
        window_slow = '0;
        window_frozen = '0;
    endfunction

    // Fold one accepted request into the shadow state; a take queues the window it reports
    function automatic void track_pacing(input fpm_in_t req);
        logic [47:0] gap;
        logic [47:0] interval;
        logic [63:0] scaled_gap;
        logic [63:0] slow_limit;
        fpm_out_t    report;
        case (req.cmd)
            CMD_FRAME: begin
                if (prior_stamp != '0 && req.timestamp_us > prior_stamp) begin
                    gap = req.timestamp_us - prior_stamp;
                    if (req.expected_interval_us == '0) begin
                        if (shortest_gap_seen == '0 || gap < shortest_gap_seen)
                            shortest_gap_seen = gap;
                        interval = shortest_gap_seen;
                    end else begin
                        interval = {24'd0, req.expected_interval_us};
                    end
                    window_frames = bump(window_frames);
                    window_interval = interval;
                    if (gap > window_max_gap)
                        window_max_gap = gap;
                    // Compare gap * 16 against interval * factor without losing bits
                    scaled_gap = {12'd0, gap, 4'd0};
                    slow_limit = {16'd0, interval} * {56'd0, cfg_slow_factor};
                    if (gap >= {24'd0, cfg_frozen_threshold})
                        window_frozen = bump(window_frozen);
                    else if (scaled_gap > slow_limit)
                        window_slow = bump(window_slow);
                end
                prior_stamp = req.timestamp_us;
            end
            CMD_TAKE: begin
                report.frame_count  = window_frames;
                report.interval_us  = window_interval;
                report.max_gap_us   = window_max_gap;
                report.slow_count   = window_slow;
                report.frozen_count = window_frozen;
                window_reports_due.push_back(report);
                clear_window();
            end
            CMD_RESTART: begin
                prior_stamp = '0;
                clear_window();
            end
            default: ;
        endcase
    endfunction

    function automatic void offer(input logic [1:0] cmd, input logic [47:0] stamp,
                                  input logic [23:0] expected);
        fpm_in_t req;
        req.cmd = cmd;
        req.timestamp_us = stamp;
        req.expected_interval_us = expected;
        pending_requests.push_back(req);
    endfunction

    function automatic logic [47:0] rand_stamp();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[47:0];
    endfunction

    function automatic void check_field(input string label, input logic [47:0] want,
                                        input logic [47:0] got);
        if (want !== got) begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, label, want, got);
            mismatches++;
        end
    endfunction

    // Driver: present queued requests in bursts of random length separated by random gaps.
    // Hold the payload while the block is stalling; advance only on acceptance.
    always @(posedge aclk) begin : request_driver
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid)
                track_pacing(s_data);
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                s_data <= pending_requests.pop_front();
                s_valid <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    // A third of the bursts run straight into the next one
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a rotating pattern that is reloaded after a random age.
    // Once asked, hold off completely for a long stretch so that the block backs up.
    always @(posedge aclk) begin : result_receiver
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (hold_off_due && !hold_off_taken) begin
            hold_off_taken = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ready_pattern[0];
            if (pattern_age == 0) begin
                case ($urandom_range(0, 3))
                    0: ready_pattern = '1;
                    1: ready_pattern = 16'($urandom);
                    2: ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom);
                endcase
                pattern_age = $urandom_range(16, 96);
            end else begin
                ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
                pattern_age--;
            end
        end
    end

    // Monitor: match every delivered window report against the oldest one predicted
    always @(posedge aclk) begin : result_monitor
        fpm_out_t due;
        if (aresetn && m_valid && m_ready) begin
            if (window_reports_due.size() == 0) begin
                $display("%0t: window report with none expected, got %p", $time, m_data);
                mismatches++;
            end else begin
                due = window_reports_due.pop_front();
                check_field("frame_count", {16'd0, due.frame_count}, {16'd0, m_data.frame_count});
                check_field("interval_us", due.interval_us, m_data.interval_us);
                check_field("max_gap_us", due.max_gap_us, m_data.max_gap_us);
                check_field("slow_count", {16'd0, due.slow_count}, {16'd0, m_data.slow_count});
                check_field("frozen_count", {16'd0, due.frozen_count},
                            {16'd0, m_data.frozen_count});
            end
        end
    end

    // Watchdog: drop the run if neither channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("frame_pacing_monitor_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // APB write with setup and access cycles, then read the register back
    task automatic write_register(input logic reg_sel, input logic [FPM_DATA_W-1:0] value);
        logic [FPM_DATA_W-1:0] readback;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        readback = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_sel == FPM_REG_FROZEN)
            cfg_frozen_threshold = value[23:0];
        else
            cfg_slow_factor = value[7:0];
        if (readback !== value) begin
            $display("%0t: register %0d readback expected 0x%0h, got 0x%0h",
                     $time, reg_sel, value, readback);
            mismatches++;
        end
    endtask

    // Wait until every request is in and every report out, then let the pipeline empty
    task automatic settle_block();
        while (pending_requests.size() != 0 || s_valid || window_reports_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Mostly steady frame sequences around a nominal interval with random content;
    // the rest is takes, restarts, stray timestamps and undecoded commands.
    task automatic queue_pacing_run(input int unsigned n_items);
        logic [47:0] stamp;
        logic [47:0] step;
        logic [23:0] nominal;
        logic [23:0] announce;
        logic [55:0] product;
        int unsigned roll;
        stamp = rand_stamp();
        nominal = 24'd16667;
        announce = '0;
        for (int unsigned i = 0; i < n_items; i++) begin
            if (i % 60 == 0) begin
                case ($urandom_range(0, 5))
                    0: nominal = 24'd16667;
                    1: nominal = 24'd8333;
                    2: nominal = 24'd33333;
                    3: nominal = 24'd6944;
                    4: nominal = 24'($urandom_range(1, 24'hFFFFFF));
                    default: nominal = 24'($urandom_range(1, 50));
                endcase
                // Keep tiny intervals announced so the shortest gap is not dragged down early
                announce = ($urandom_range(0, 1) == 0 && nominal > 50) ? 24'd0 : nominal;
            end
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                        step = {24'd0, nominal} - 48'(nominal / 16)
                               + 48'($urandom_range(0, nominal / 8));
                    5: begin
                        // Right on the slow limit, and one past it
                        product = {32'd0, nominal} * {48'd0, cfg_slow_factor};
                        step = product[51:4] + 48'($urandom_range(0, 1));
                    end
                    6: step = {24'd0, nominal} + 48'(nominal / 2)
                              + 48'($urandom_range(0, nominal));
                    7: step = {24'd0, cfg_frozen_threshold} + 48'($urandom_range(0, 2))
                              - 48'(cfg_frozen_threshold != '0);
                    8: step = rand_stamp() >> $urandom_range(8, 24);
                    default: step = 48'd0 - 48'($urandom_range(0, 1000));
                endcase
                stamp = stamp + step;
                offer(CMD_FRAME, stamp, ($urandom_range(0, 15) == 0) ? 24'($urandom) : announce);
            end else if (roll < 85) begin
                offer(CMD_TAKE, rand_stamp(), 24'($urandom));
            end else if (roll < 89) begin
                offer(CMD_RESTART, rand_stamp(), 24'($urandom));
                stamp = ($urandom_range(0, 3) == 0) ? rand_stamp()
                                                    : 48'($urandom_range(1, 1000000));
            end else if (roll < 95) begin
                offer(CMD_FRAME, ($urandom_range(0, 2) == 0) ? '0 : rand_stamp(),
                      24'($urandom));
            end else begin
                offer(CMD_UNUSED, rand_stamp(), 24'($urandom));
            end
        end
    endtask

    initial begin
        logic [23:0] frozen_setting;
        logic [7:0]  slow_setting;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed opening at the reset register values
        offer(CMD_TAKE, '0, '0);                           // empty window
        offer(CMD_UNUSED, '1, '1);                         // ignored with all bits set
        offer(CMD_FRAME, '0, '0);                          // no timestamp held yet
        offer(CMD_FRAME, 48'd1000, '0);                    // first stamp, not measured
        offer(CMD_FRAME, 48'd2000, '0);                    // gap 1000 sets shortest gap
        offer(CMD_FRAME, 48'd2000, '0);                    // equal stamp, not measured
        offer(CMD_FRAME, 48'd1500, '0);                    // earlier stamp, not measured
        offer(CMD_FRAME, 48'd3000, '0);                    // exactly on the slow limit
        offer(CMD_FRAME, 48'd4501, '0);                    // one past the slow limit
        offer(CMD_FRAME, 48'd21167, 24'd16667);            // known interval
        offer(CMD_FRAME, 48'd721167, 24'd16667);           // exactly frozen
        offer(CMD_FRAME, 48'd1421166, 24'd16667);          // just below frozen, slow
        offer(CMD_TAKE, '1, '1);
        offer(CMD_FRAME, '0, 24'hFFFFFF);                  // zero stamp drops the last one
        offer(CMD_FRAME, 48'd5000, '0);
        offer(CMD_FRAME, 48'd5500, '0);                    // shortest gap shrinks to 500
        offer(CMD_FRAME, 48'hFFFF_FFFF_FFFF, 24'hFFFFFF);  // widest gap
        offer(CMD_TAKE, '0, '0);
        offer(CMD_RESTART, rand_stamp(), 24'($urandom));
        offer(CMD_FRAME, 48'd10, '0);                      // last stamp was cleared
        offer(CMD_FRAME, 48'd11, 24'hFFFFFF);              // measured again after the restart
        offer(CMD_TAKE, '0, '0);
        offer(CMD_TAKE, '0, '0);                           // window just cleared
        offer(CMD_UNUSED, '0, '0);
        settle_block();

        // Random phases across register settings, extremes and odd values included
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin frozen_setting = 24'hFFFFFF; slow_setting = 8'd255; end
                1: begin frozen_setting = 24'd250000; slow_setting = 8'd16; end
                2: begin frozen_setting = 24'd40000;  slow_setting = 8'd20; end
                3: begin
                    frozen_setting = 24'($urandom_range(1, 24'hFFFFFF));
                    slow_setting = 8'($urandom_range(16, 255));
                end
                4: begin frozen_setting = 24'd0; slow_setting = 8'd0; end
                default: begin frozen_setting = 24'd1; slow_setting = 8'd15; end
            endcase
            write_register(FPM_REG_FROZEN, {8'd0, frozen_setting});
            write_register(FPM_REG_SLOW, {24'd0, slow_setting});
            if (phase == PRESSURE_PHASE)
                hold_off_due <= 1'b1;
            queue_pacing_run(PHASE_ITEMS);
            settle_block();
        end

        if (mismatches == 0)
            $display("frame_pacing_monitor_test passed");
        else
            $display("frame_pacing_monitor_test failed");
        $finish;
    end

endmodule
